// File: src/pop3cs_pkg.sv
// Package for the POP3 login credential sniffer.
// Holds phase, event and command codes, character constants and the case folding helper.
// Has no dependencies.
`timescale 1ns / 1ps

package pop3cs_pkg;

    // Width of the phase and event codes.
    localparam int PhaseW = 3;
    localparam int EventW = 3;

    typedef logic [PhaseW-1:0] phase_t;
    typedef logic [EventW-1:0] event_t;
    typedef logic [1:0]        cmd_t;
    typedef logic [7:0]        byte_t;

    // Session phases.
    localparam phase_t PH_GREET = 3'd0;
    localparam phase_t PH_UCMD  = 3'd1;
    localparam phase_t PH_PCMD  = 3'd2;
    localparam phase_t PH_UARG  = 3'd3;
    localparam phase_t PH_PARG  = 3'd4;
    localparam phase_t PH_STOP  = 3'd5;

    // Events reported with each result.
    localparam event_t EV_NONE = 3'd0;
    localparam event_t EV_GOK  = 3'd1;
    localparam event_t EV_GBAD = 3'd2;
    localparam event_t EV_UCHR = 3'd3;
    localparam event_t EV_PCHR = 3'd4;
    localparam event_t EV_UEND = 3'd5;
    localparam event_t EV_PEND = 3'd6;
    localparam event_t EV_BAD  = 3'd7;

    // Input commands.
    localparam cmd_t CMD_SERVER  = 2'd0;
    localparam cmd_t CMD_CLIENT  = 2'd1;
    localparam cmd_t CMD_SKIP    = 2'd2;
    localparam cmd_t CMD_RESTART = 2'd3;

    // Characters.
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_O     = 8'h4F;
    localparam byte_t CH_K     = 8'h4B;
    localparam byte_t CH_U     = 8'h55;
    localparam byte_t CH_S     = 8'h53;
    localparam byte_t CH_E     = 8'h45;
    localparam byte_t CH_R     = 8'h52;
    localparam byte_t CH_P     = 8'h50;
    localparam byte_t CH_A     = 8'h41;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_LOW_A = 8'h61;
    localparam byte_t CH_LOW_Z = 8'h7A;
    localparam byte_t CASE_GAP = 8'h20;

    // Word lengths and counter reload values.
    localparam int    WordLen   = 5;
    localparam int    GreetLen  = 3;
    localparam byte_t WORD_LOAD = 8'd5;
    localparam byte_t GREET_LOAD = 8'd3;

    // Folds a lower-case ASCII letter to upper case.
    function automatic byte_t upcase(input byte_t b);
        byte_t r;
        r = b;
        if (b >= CH_LOW_A && b <= CH_LOW_Z)
        begin
            r = b - CASE_GAP;
        end
        return r;
    endfunction

endpackage

// File: src/pop3_login_credential_sniffer_top.sv
// Top level of the POP3 login credential sniffer: session tracking and result register.
// Depends on pop3cs_pkg for codes, characters and the case folding helper.
`timescale 1ns / 1ps

// The sniffer takes one byte transaction per clock cycle from either direction of a POP3
// session (command 0 for a server byte, 1 for a client byte, 2 to skip the greeting check,
// 3 to restart at the greeting) and returns exactly one result transaction for each input
// transaction: the phase after the byte, an event code, and the captured user or password
// character when the event is a character event (zero otherwise). All the work for a byte
// is a short compare and counter update done in the cycle it is accepted; the result then
// sits in a single output register. The input side is stalled only while that register
// holds a result that the downstream side is stalling, so with no downstream back-pressure
// the block sustains one byte per cycle. Each user name and each password yields at most
// ARG_LEN-1 characters; the next byte after that ends the argument.
module pop3_login_credential_sniffer_top
    import pop3cs_pkg::*;
#(
    parameter int ARG_LEN = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Input channel.
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   command,
    input  logic [7:0]   data_byte,
    // Result channel.
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   phase,
    output logic [2:0]   event_res,
    output logic [7:0]   out_byte
);

    // Characters allowed per argument; the counter is loaded with this on entry.
    localparam byte_t ARG_LOAD = byte_t'(ARG_LEN - 1);

    // Session state.
    phase_t phase_reg,      phase_next;
    byte_t  left_count_reg, left_count_next;
    logic   skip_line_reg,  skip_line_next;

    // Holds the command word or greeting being collected. Entries are always written
    // before the word they belong to is compared, so they need no reset.
    byte_t  word_buffer_reg [WordLen];
    logic        buf_we;
    logic [2:0]  buf_idx;
    byte_t       buf_data;

    // Result register.
    logic   out_valid_reg;
    phase_t phase_out_reg;
    event_t event_out_reg;
    byte_t  byte_out_reg;

    event_t ev_next;
    byte_t  cap_next;

    logic   accept;

    // Working values for the byte being handled.
    byte_t  greet_left;
    byte_t  cmd_left;
    byte_t  left_dec;
    byte_t  up_byte;
    logic   is_line_end;
    logic   word_user;
    logic   word_pass;
    logic   greet_ok;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign out_valid = out_valid_reg;
    assign phase     = phase_out_reg;
    assign event_res = event_out_reg;
    assign out_byte  = byte_out_reg;

    // Counter values with out-of-range contents treated as the start of a fresh word.
    assign greet_left = (left_count_reg >= 8'd1 && left_count_reg <= GREET_LOAD)
                        ? left_count_reg : GREET_LOAD;
    assign cmd_left   = (left_count_reg >= 8'd1 && left_count_reg <= WORD_LOAD)
                        ? left_count_reg : WORD_LOAD;

    assign up_byte     = upcase(data_byte);
    assign is_line_end = (data_byte == CH_CR) || (data_byte == CH_LF);

    // Completed-word compares: the last byte of a word is the byte now arriving.
    assign word_user = (word_buffer_reg[0] == CH_U) && (word_buffer_reg[1] == CH_S)
                    && (word_buffer_reg[2] == CH_E) && (word_buffer_reg[3] == CH_R)
                    && (up_byte == CH_SPACE);
    assign word_pass = (word_buffer_reg[0] == CH_P) && (word_buffer_reg[1] == CH_A)
                    && (word_buffer_reg[2] == CH_S) && (word_buffer_reg[3] == CH_S)
                    && (up_byte == CH_SPACE);
    assign greet_ok  = (word_buffer_reg[0] == CH_PLUS) && (word_buffer_reg[1] == CH_O)
                    && (data_byte == CH_K);

    always_comb
    begin
        phase_next      = phase_reg;
        left_count_next = left_count_reg;
        skip_line_next  = skip_line_reg;
        ev_next         = EV_NONE;
        cap_next        = 8'd0;
        buf_we          = 1'b0;
        buf_idx         = 3'd0;
        buf_data        = data_byte;
        left_dec        = 8'd0;

        unique case (command)
            CMD_SERVER:
            begin
                if (phase_reg == PH_GREET)
                begin
                    left_dec = greet_left - 8'd1;
                    buf_we   = 1'b1;
                    buf_idx  = 3'(GREET_LOAD[2:0] - greet_left[2:0]);
                    buf_data = data_byte;
                    left_count_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        if (greet_ok)
                        begin
                            phase_next      = PH_UCMD;
                            left_count_next = WORD_LOAD;
                            ev_next         = EV_GOK;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                            ev_next    = EV_GBAD;
                        end
                    end
                end
            end
            CMD_CLIENT:
            begin
                // Client bytes only matter between the greeting and a stop. While a bad
                // line is being skipped, everything up to the newline is dropped.
                if (phase_reg >= PH_UCMD && phase_reg <= PH_PARG
                    && !(skip_line_reg && data_byte != CH_LF))
                begin
                    skip_line_next = 1'b0;
                    unique case (phase_reg) inside
                        PH_UCMD, PH_PCMD:
                        begin
                            left_count_next = cmd_left;
                            if (data_byte == CH_LF && cmd_left == WORD_LOAD)
                            begin
                                // A lone newline before any command byte is ignored.
                                ev_next = EV_NONE;
                            end
                            else if (is_line_end)
                            begin
                                phase_next      = PH_UCMD;
                                left_count_next = WORD_LOAD;
                            end
                            else
                            begin
                                left_dec = cmd_left - 8'd1;
                                buf_we   = 1'b1;
                                buf_idx  = 3'(WORD_LOAD[2:0] - cmd_left[2:0]);
                                buf_data = up_byte;
                                left_count_next = left_dec;
                                if (left_dec == 8'd0)
                                begin
                                    if (phase_reg == PH_PCMD && word_pass)
                                    begin
                                        phase_next      = PH_PARG;
                                        left_count_next = ARG_LOAD;
                                    end
                                    else if (word_user)
                                    begin
                                        phase_next      = PH_UARG;
                                        left_count_next = ARG_LOAD;
                                    end
                                    else
                                    begin
                                        left_count_next = WORD_LOAD;
                                        skip_line_next  = 1'b1;
                                        ev_next         = EV_BAD;
                                    end
                                end
                            end
                        end
                        PH_UARG, PH_PARG:
                        begin
                            if (is_line_end || left_count_reg == 8'd0)
                            begin
                                phase_next      = PH_PCMD;
                                left_count_next = WORD_LOAD;
                                ev_next = (phase_reg == PH_UARG) ? EV_UEND : EV_PEND;
                            end
                            else
                            begin
                                left_count_next = left_count_reg - 8'd1;
                                cap_next        = data_byte;
                                ev_next = (phase_reg == PH_UARG) ? EV_UCHR : EV_PCHR;
                            end
                        end
                        default:
                        begin
                            ev_next = EV_NONE;
                        end
                    endcase
                end
            end
            CMD_SKIP:
            begin
                skip_line_next  = 1'b0;
                phase_next      = PH_UCMD;
                left_count_next = WORD_LOAD;
            end
            CMD_RESTART:
            begin
                skip_line_next  = 1'b0;
                phase_next      = PH_GREET;
                left_count_next = GREET_LOAD;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Session state and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_GREET;
            left_count_reg <= GREET_LOAD;
            skip_line_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                left_count_reg <= left_count_next;
                skip_line_reg  <= skip_line_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Word buffer and result payload; neither needs a reset.
    always_ff @(posedge clk)
    begin
        if (accept && buf_we)
        begin
            word_buffer_reg[buf_idx] <= buf_data;
        end
        if (accept)
        begin
            phase_out_reg <= phase_next;
            event_out_reg <= ev_next;
            byte_out_reg  <= cap_next;
        end
    end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the POP3 login credential sniffer top level.
// Depends on pop3cs_pkg and pop3_login_credential_sniffer_top; predicts every result in-line.
`timescale 1ns / 1ps

module testbench;
    import pop3cs_pkg::*;

    localparam int ArgLen = 256;
    localparam byte_t ArgLoad = byte_t'(ArgLen - 1);
    // Stop the random part after this many bytes that the sniffer actually acts on.
    localparam int RandItems = 750;
    // Length of the one long downstream hold-off, in cycles.
    localparam int LongHold = 64;
    // The sniffer holds each result in a single output register, so this drain is plenty to catch a stray result.
    localparam int DrainCycles = 8;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        phase_t ph;
        event_t ev;
        byte_t  ch;
        bit     used;
    } sniff_report_t;

    typedef struct packed {
        cmd_t  cmd;
        byte_t b;
    } stream_byte_t;

    typedef struct packed {
        cmd_t   cmd;
        byte_t  b;
        bit     typed;
        phase_t ph;
        event_t ev;
        byte_t  ch;
    } dir_row_t;

    // Directed bytes. Rows marked typed carry a result that can be read off the protocol
    // directly; the others are checked against the predictor.
    localparam int DirCount = 36;
    localparam dir_row_t DirRows [DirCount] = '{
        // A client byte before the greeting is ignored.
        '{CMD_CLIENT, CH_U,   1'b1, PH_GREET, EV_NONE, 8'h00},
        '{CMD_SERVER, CH_PLUS, 1'b1, PH_GREET, EV_NONE, 8'h00},
        '{CMD_SERVER, CH_O,   1'b1, PH_GREET, EV_NONE, 8'h00},
        '{CMD_SERVER, CH_K,   1'b1, PH_UCMD,  EV_GOK,  8'h00},
        // Server bytes after the greeting are ignored.
        '{CMD_SERVER, "Z",    1'b1, PH_UCMD,  EV_NONE, 8'h00},
        // A newline before any command byte is ignored.
        '{CMD_CLIENT, CH_LF,  1'b1, PH_UCMD,  EV_NONE, 8'h00},
        // Mixed-case user command.
        '{CMD_CLIENT, "u",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "S",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "e",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "r",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, " ",    1'b1, PH_UARG,  EV_NONE, 8'h00},
        // Extreme argument bytes pass straight through.
        '{CMD_CLIENT, 8'hFF,  1'b1, PH_UARG,  EV_UCHR, 8'hFF},
        '{CMD_CLIENT, 8'h00,  1'b1, PH_UARG,  EV_UCHR, 8'h00},
        '{CMD_CLIENT, CH_CR,  1'b1, PH_PCMD,  EV_UEND, 8'h00},
        // The newline of the CRLF pair is ignored.
        '{CMD_CLIENT, CH_LF,  1'b1, PH_PCMD,  EV_NONE, 8'h00},
        '{CMD_CLIENT, "p",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "a",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "s",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "S",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, " ",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "x",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, CH_LF,  1'b1, PH_PCMD,  EV_PEND, 8'h00},
        // Unknown command, then the rest of its line is dropped.
        '{CMD_CLIENT, "Q",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "U",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "I",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, "T",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, " ",    1'b1, PH_PCMD,  EV_BAD,  8'h00},
        '{CMD_CLIENT, "!",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, CH_LF,  1'b1, PH_PCMD,  EV_NONE, 8'h00},
        // A line end inside a command word falls back to the user phase.
        '{CMD_CLIENT, "U",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_CLIENT, CH_CR,  1'b1, PH_UCMD,  EV_NONE, 8'h00},
        // Restart, then a bad greeting stops the session.
        '{CMD_RESTART, 8'h00, 1'b1, PH_GREET, EV_NONE, 8'h00},
        '{CMD_SERVER, "-",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_SERVER, "E",    1'b0, PH_GREET, EV_NONE, 8'h00},
        '{CMD_SERVER, "R",    1'b1, PH_STOP,  EV_GBAD, 8'h00},
        // Skipping the greeting check resumes from the stopped phase.
        '{CMD_SKIP,   8'h00,  1'b1, PH_UCMD,  EV_NONE, 8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_SERVER;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  res_phase;
    logic [2:0]  res_event;
    logic [7:0]  res_byte;

    // Predicted session state.
    phase_t sess_phase = PH_GREET;
    byte_t  chars_left = GREET_LOAD;
    byte_t  cmd_chars [WordLen] = '{default: 8'h00};
    bit     dropping_line = 1'b0;

    sniff_report_t report_q [$];
    stream_byte_t  session_bytes [$];
    int  error_count = 0;
    int  bytes_counted = 0;
    int  cycle_count = 0;
    bit  tx_burst = 1'b0;
    bit  long_hold_req = 1'b0;

    pop3_login_credential_sniffer_top #(
        .ARG_LEN(ArgLen)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .phase     (res_phase),
        .event_res (res_event),
        .out_byte  (res_byte)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, report_q.size());
            $display("FAIL pop3_login_credential_sniffer_top");
            $finish;
        end
    end

    // Advances the predicted session by one byte and returns the result it should give.
    function automatic sniff_report_t sniff_step(input cmd_t c, input byte_t b);
        sniff_report_t r;
        logic [39:0]   word;
        bit            is_user;
        r = '0;
        case (c)
            CMD_SERVER:
            begin
                if (sess_phase == PH_GREET)
                begin
                    r.used = 1'b1;
                    if (chars_left < 8'd1 || chars_left > GREET_LOAD)
                    begin
                        chars_left = GREET_LOAD;
                    end
                    cmd_chars[int'(GREET_LOAD - chars_left)] = b;
                    chars_left--;
                    if (chars_left == 8'd0)
                    begin
                        if (cmd_chars[0] == CH_PLUS && cmd_chars[1] == CH_O
                            && cmd_chars[2] == CH_K)
                        begin
                            sess_phase = PH_UCMD;
                            chars_left = WORD_LOAD;
                            r.ev = EV_GOK;
                        end
                        else
                        begin
                            sess_phase = PH_STOP;
                            r.ev = EV_GBAD;
                        end
                    end
                end
            end
            CMD_CLIENT:
            begin
                if (sess_phase >= PH_UCMD && sess_phase <= PH_PARG
                    && !(dropping_line && b != CH_LF))
                begin
                    r.used = 1'b1;
                    dropping_line = 1'b0;
                    if (sess_phase == PH_UCMD || sess_phase == PH_PCMD)
                    begin
                        if (chars_left < 8'd1 || chars_left > WORD_LOAD)
                        begin
                            chars_left = WORD_LOAD;
                        end
                        if (b == CH_LF && chars_left == WORD_LOAD)
                        begin
                            r.used = 1'b0;
                        end
                        else if (b == CH_CR || b == CH_LF)
                        begin
                            sess_phase = PH_UCMD;
                            chars_left = WORD_LOAD;
                        end
                        else
                        begin
                            cmd_chars[int'(WORD_LOAD - chars_left)] =
                                (b >= CH_LOW_A && b <= CH_LOW_Z) ? b - CASE_GAP : b;
                            chars_left--;
                            if (chars_left == 8'd0)
                            begin
                                word = {cmd_chars[0], cmd_chars[1], cmd_chars[2],
                                        cmd_chars[3], cmd_chars[4]};
                                if (sess_phase == PH_PCMD && word == "PASS ")
                                begin
                                    sess_phase = PH_PARG;
                                    chars_left = ArgLoad;
                                end
                                else if (word == "USER ")
                                begin
                                    sess_phase = PH_UARG;
                                    chars_left = ArgLoad;
                                end
                                else
                                begin
                                    chars_left = WORD_LOAD;
                                    dropping_line = 1'b1;
                                    r.ev = EV_BAD;
                                end
                            end
                        end
                    end
                    else
                    begin
                        is_user = (sess_phase == PH_UARG);
                        if (b == CH_CR || b == CH_LF || chars_left == 8'd0)
                        begin
                            sess_phase = PH_PCMD;
                            chars_left = WORD_LOAD;
                            r.ev = is_user ? EV_UEND : EV_PEND;
                        end
                        else
                        begin
                            chars_left--;
                            r.ch = b;
                            r.ev = is_user ? EV_UCHR : EV_PCHR;
                        end
                    end
                end
            end
            CMD_SKIP:
            begin
                r.used = 1'b1;
                dropping_line = 1'b0;
                sess_phase = PH_UCMD;
                chars_left = WORD_LOAD;
            end
            default:
            begin
                r.used = 1'b1;
                dropping_line = 1'b0;
                sess_phase = PH_GREET;
                chars_left = GREET_LOAD;
            end
        endcase
        r.ph = sess_phase;
        return r;
    endfunction

    // Offers one byte transaction after a random gap and records its expected result once
    // it is accepted. A typed result, when given, replaces the predicted one.
    task automatic drive_byte(input cmd_t c, input byte_t b, input bit typed,
                              input sniff_report_t fixed_res);
        int            gap;
        sniff_report_t r;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        r = sniff_step(c, b);
        if (r.used)
        begin
            bytes_counted++;
        end
        report_q.push_back(typed ? fixed_res : r);
    endtask

    function automatic void push_byte(input cmd_t c, input byte_t b);
        session_bytes.push_back('{cmd: c, b: b});
    endfunction

    function automatic byte_t rand_case(input byte_t c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
        begin
            return c + CASE_GAP;
        end
        return c;
    endfunction

    function automatic void push_text(input cmd_t c, input string s, input bit fold);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(c, fold ? rand_case(s[i]) : byte_t'(s[i]));
        end
    endfunction

    // Argument bytes are anything but a line end.
    function automatic void push_arg(input int n);
        byte_t b;
        for (int i = 0; i < n; i++)
        begin
            b = byte_t'($urandom_range(0, 255));
            if (b == CH_CR || b == CH_LF)
            begin
                b = b ^ 8'h40;
            end
            push_byte(CMD_CLIENT, b);
        end
    endfunction

    function automatic void push_eol();
        case ($urandom_range(0, 3))
            0: push_byte(CMD_CLIENT, CH_LF);
            1: push_byte(CMD_CLIENT, CH_CR);
            default:
            begin
                push_byte(CMD_CLIENT, CH_CR);
                push_byte(CMD_CLIENT, CH_LF);
            end
        endcase
    endfunction

    // Plans one session: mostly a proper greeting followed by command lines with random
    // content, sometimes plain noise. The long flags drive an argument to or past its limit.
    function automatic void plan_session(input bit long_user, input bit long_pass);
        int    kind;
        int    n;
        int    r;
        string user_cmd;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat (24)
            begin
                r = $urandom_range(0, 15);
                push_byte(r < 4 ? CMD_SERVER : r < 14 ? CMD_CLIENT : r == 14 ? CMD_SKIP
                          : CMD_RESTART, byte_t'($urandom_range(0, 255)));
            end
            return;
        end
        if (kind == 1)
        begin
            push_byte(CMD_SKIP, byte_t'($urandom_range(0, 255)));
        end
        else
        begin
            push_byte(CMD_RESTART, byte_t'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
            begin
                push_byte(CMD_SERVER, $urandom_range(0, 1) ? CH_PLUS
                                      : byte_t'($urandom_range(0, 255)));
                push_byte(CMD_SERVER, byte_t'($urandom_range(0, 255)));
                push_byte(CMD_SERVER, $urandom_range(0, 1) ? CH_K
                                      : byte_t'($urandom_range(0, 255)));
            end
            else
            begin
                push_text(CMD_SERVER, "+OK", 1'b0);
            end
            repeat ($urandom_range(0, 3)) push_byte(CMD_SERVER, byte_t'($urandom_range(0, 255)));
        end
        if (long_user || long_pass)
        begin
            push_text(CMD_CLIENT, "USER ", 1'b1);
            push_arg(long_user ? ArgLen - 1 + $urandom_range(0, 2) : 4);
            push_eol();
            if (long_pass)
            begin
                push_text(CMD_CLIENT, "PASS ", 1'b1);
                push_arg(ArgLen - 1 + $urandom_range(0, 2));
                push_eol();
            end
        end
        repeat ($urandom_range(2, 6))
        begin
            r = $urandom_range(0, 9);
            if (r <= 3)
            begin
                push_text(CMD_CLIENT, "USER ", 1'b1);
                push_arg($urandom_range(0, 10));
                push_eol();
            end
            else if (r <= 6)
            begin
                push_text(CMD_CLIENT, "PASS ", 1'b1);
                push_arg($urandom_range(0, 10));
                push_eol();
            end
            else if (r == 7)
            begin
                // Unknown command word with a random tail; the newline may be missing.
                repeat (5) push_byte(CMD_CLIENT, rand_case(byte_t'($urandom_range(8'h41, 8'h5A))));
                repeat ($urandom_range(0, 4)) push_byte(CMD_CLIENT, byte_t'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0)
                begin
                    push_byte(CMD_CLIENT, CH_LF);
                end
            end
            else if (r == 8)
            begin
                n = $urandom_range(1, 4);
                user_cmd = "USER";
                push_text(CMD_CLIENT, user_cmd.substr(0, n - 1), 1'b1);
                push_eol();
            end
            else
            begin
                repeat ($urandom_range(1, 2)) push_byte(CMD_SERVER, byte_t'($urandom_range(0, 255)));
                push_eol();
            end
        end
    endfunction

    initial
    begin : stimulus
        stream_byte_t sb;
        int           session;
        @(posedge rst_n);
        @(posedge clk);
        for (int i = 0; i < DirCount; i++)
        begin
            drive_byte(DirRows[i].cmd, DirRows[i].b, DirRows[i].typed,
                       '{ph: DirRows[i].ph, ev: DirRows[i].ev, ch: DirRows[i].ch, used: 1'b1});
        end

        bytes_counted = 0;
        session = 0;
        while (bytes_counted < RandItems)
        begin
            plan_session(session == 0, session == 1);
            if (session == 2)
            begin
                // Keep offering bytes back to back while the result side holds off, so the
                // sniffer fills up and stalls its input.
                tx_burst = 1'b1;
                long_hold_req = 1'b1;
            end
            if (session == 5)
            begin
                in_valid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (report_q.size() != 0);
            end
            while (session_bytes.size() != 0)
            begin
                sb = session_bytes.pop_front();
                drive_byte(sb.cmd, sb.b, 1'b0, '0);
            end
            session++;
            tx_burst = ($urandom_range(0, 3) == 0);
        end

        in_valid <= 1'b0;
        while (report_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0 && report_q.size() == 0)
        begin
            $display("PASS pop3_login_credential_sniffer_top");
        end
        else
        begin
            $display("FAIL pop3_login_credential_sniffer_top");
        end
        $finish;
    end

    function automatic void check_field(input string name, input integer want,
                                        input integer got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Result side: checks each accepted result against the oldest expectation and stalls
    // for a random number of cycles after each one, or for a long stretch when asked.
    initial
    begin : result_side
        sniff_report_t want;
        int            hold_left;
        bit            rx_burst;
        hold_left = 0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (report_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result mismatch: expected none, actual phase %0d event %0d byte %0d",
                             $time, res_phase, res_event, res_byte);
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("phase", want.ph, res_phase);
                    check_field("event", want.ev, res_event);
                    check_field("out_byte", want.ch, res_byte);
                end
                hold_left = rx_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 31) == 0)
                begin
                    rx_burst = !rx_burst;
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LongHold;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

endmodule
